FILE: sv/dstd_pkg.sv
package dstd_pkg;

  localparam int unsigned MAX_TILES_DEFAULT = 4096;

  // Widest tile index that the MAX_TILES range can call for.
  localparam int unsigned IDX_MAX_W = 16;

  localparam int unsigned WORD_W       = 16;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned SIZE_W       = 48;
  localparam int unsigned OFFSET_W     = 48;
  localparam int unsigned TILE_INDEX_W = 12;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned ERR_W        = 2;
  localparam int unsigned CNT_CFG_W    = 13;
  localparam int unsigned DATA_START_W = 47;
  localparam int unsigned CFG_INDEX_W  = 1;
  localparam int unsigned CFG_DATA_W   = 47;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // First high word of a negative two-word size delta.
  localparam logic [WORD_W-1:0] ESC_NEG_MIN = 16'hff00;

  localparam logic [KIND_W-1:0] KIND_KEY    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COMP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNCOMP = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd3;

  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NEGATIVE  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_TILE_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DATA_START = 1'd1;

  // One classified result on its way from the front to the back.
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [IDX_MAX_W-1:0] tile_index;
    logic [IDX_MAX_W-1:0] mem_index;
    logic [VALUE_W-1:0]   value;
    logic [ERR_W-1:0]     error_code;
    logic                 last;
    logic                 write_size;
    logic                 offset_start;
  } dstd_op_t;

endpackage

FILE: sv/dstd_if.sv
interface dstd_word_if import dstd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic              stream_end;

  modport source(output valid, word, stream_end, input ready);
  modport sink(input valid, word, stream_end, output ready);
endinterface

interface dstd_result_if import dstd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [TILE_INDEX_W-1:0] tile_index;
  logic [VALUE_W-1:0]      value;
  logic [OFFSET_W-1:0]     data_offset;
  logic [ERR_W-1:0]        error_code;
  logic                    last;

  modport source(output valid, kind, tile_index, value, data_offset, error_code, last,
                 input ready);
  modport sink(input valid, kind, tile_index, value, data_offset, error_code, last,
               output ready);
endinterface

FILE: sv/dstd_front.sv
module dstd_front import dstd_pkg::*; #(
  parameter int unsigned MAX_TILES = MAX_TILES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CNT_CFG_W-1:0] tile_count,
  dstd_word_if.sink            words,
  output logic                 push_valid,
  output dstd_op_t             push_op,
  input  logic                 push_ready
);

  localparam int unsigned AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int unsigned CW = (AW + 1 > CNT_CFG_W) ? AW + 1 : CNT_CFG_W;

  localparam logic [1:0] PHASE_KEYS   = 2'd0;
  localparam logic [1:0] PHASE_COMP   = 2'd1;
  localparam logic [1:0] PHASE_UNCOMP = 2'd2;

  logic [1:0]         phase, phase_next;
  logic [AW-1:0]      tile_counter, tile_counter_next;
  logic               escape, escape_next;
  logic [WORD_W-1:0]  partial_hi, partial_hi_next;
  logic [VALUE_W-1:0] key_sum, key_sum_next;
  logic [SIZE_W-1:0]  running_size, running_size_next;
  logic               discard, discard_next;

  logic [CW-1:0]      cnt_cfg, cnt_max, cnt, counter_inc;
  logic               wrap;
  logic               accept;
  logic [33:0]        esc_delta, plain_delta, delta;
  logic [49:0]        new_size;
  logic [VALUE_W-1:0] extra, key_add;
  logic               element, negative, done, restart;
  logic [VALUE_W-1:0] val;

  assign cnt_cfg = CW'(tile_count);
  assign cnt_max = CW'(MAX_TILES);
  assign cnt     = (cnt_cfg > cnt_max) ? cnt_max : cnt_cfg;

  assign counter_inc = CW'(tile_counter) + CW'(1);
  assign wrap        = counter_inc >= cnt;

  assign words.ready = push_ready;
  assign accept      = words.valid && push_ready;

  // A two-word delta: the high word is signed when it lies in the top 256 codes.
  assign esc_delta   = (partial_hi >= ESC_NEG_MIN) ?
                       {2'b11, partial_hi, words.word} :
                       {3'b000, partial_hi[14:0], words.word};
  // A one-word delta is the low 15 bits read as a signed number.
  assign plain_delta = {{19{words.word[14]}}, words.word[14:0]};
  assign delta       = escape ? esc_delta : plain_delta;
  assign new_size    = {2'b00, running_size} + {{16{delta[33]}}, delta};

  assign extra   = escape ? {1'b0, partial_hi[14:0], words.word} : {16'b0, words.word};
  assign key_add = key_sum + {16'b0, words.word};

  always_comb begin
    phase_next        = phase;
    tile_counter_next = tile_counter;
    escape_next       = escape;
    partial_hi_next   = partial_hi;
    key_sum_next      = key_sum;
    running_size_next = running_size;
    discard_next      = discard;
    element           = 1'b0;
    negative          = 1'b0;
    done              = 1'b0;
    restart           = 1'b0;
    val               = '0;
    push_valid        = 1'b0;
    push_op           = '0;
    push_op.error_code = ERR_NONE;

    if (accept) begin
      if (discard || cnt == '0) begin
        restart = words.stream_end;
      end else begin
        unique case (phase)
          PHASE_KEYS: begin
            key_sum_next = key_add;
            element      = 1'b1;
            val          = key_add;
          end
          PHASE_COMP: begin
            if (!escape && words.word[15]) begin
              escape_next     = 1'b1;
              partial_hi_next = words.word;
            end else begin
              escape_next = 1'b0;
              if (new_size[49]) begin
                negative = 1'b1;
              end else begin
                running_size_next = new_size[SIZE_W-1:0];
                element           = 1'b1;
                val               = new_size[VALUE_W-1:0];
              end
            end
          end
          PHASE_UNCOMP: begin
            if (!escape && words.word[15]) begin
              escape_next     = 1'b1;
              partial_hi_next = words.word;
            end else begin
              escape_next = 1'b0;
              element     = 1'b1;
              val         = extra;
            end
          end
          default: begin
          end
        endcase

        if (element) begin
          if (wrap) begin
            tile_counter_next = '0;
            if (phase == PHASE_KEYS) begin
              phase_next        = PHASE_COMP;
              running_size_next = '0;
            end else if (phase == PHASE_COMP) begin
              phase_next           = PHASE_UNCOMP;
              // The back takes the data offset base as this beat goes through.
              push_op.offset_start = 1'b1;
            end else begin
              done = 1'b1;
            end
          end else begin
            tile_counter_next = counter_inc[AW-1:0];
          end
        end

        push_op.mem_index  = IDX_MAX_W'(tile_counter);
        push_op.value      = val;
        push_op.write_size = element && (phase == PHASE_COMP);

        priority if (negative) begin
          push_valid         = 1'b1;
          push_op.kind       = KIND_ERROR;
          push_op.tile_index = IDX_MAX_W'(tile_counter);
          push_op.error_code = ERR_NEGATIVE;
          push_op.last       = 1'b1;
          restart            = words.stream_end;
          discard_next       = !words.stream_end;
        end else if (words.stream_end && !done) begin
          // Truncation reports the entry that was still being read.
          push_valid         = 1'b1;
          push_op.kind       = KIND_ERROR;
          push_op.tile_index = IDX_MAX_W'(tile_counter_next);
          push_op.error_code = ERR_TRUNCATED;
          push_op.last       = 1'b1;
          restart            = 1'b1;
        end else if (element) begin
          push_valid         = 1'b1;
          push_op.kind       = (phase == PHASE_KEYS) ? KIND_KEY :
                               (phase == PHASE_COMP) ? KIND_COMP : KIND_UNCOMP;
          push_op.tile_index = IDX_MAX_W'(tile_counter);
          push_op.last       = done;
          if (done) begin
            restart      = words.stream_end;
            discard_next = !words.stream_end;
          end
        end else begin
        end
      end
    end

    if (restart) begin
      phase_next        = PHASE_KEYS;
      tile_counter_next = '0;
      escape_next       = 1'b0;
      partial_hi_next   = '0;
      key_sum_next      = '0;
      running_size_next = '0;
      discard_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PHASE_KEYS;
      tile_counter <= '0;
      escape       <= 1'b0;
      partial_hi   <= '0;
      key_sum      <= '0;
      running_size <= '0;
      discard      <= 1'b0;
    end else begin
      phase        <= phase_next;
      tile_counter <= tile_counter_next;
      escape       <= escape_next;
      partial_hi   <= partial_hi_next;
      key_sum      <= key_sum_next;
      running_size <= running_size_next;
      discard      <= discard_next;
    end
  end

`ifndef SYNTH
  // Once a table is finished or has failed, nothing more is queued until stream end.
  assert property (@(posedge clk) disable iff (rst) discard |-> !push_valid)
    else $error("front queued a result while discarding");
`endif

endmodule

FILE: sv/dstd_fifo.sv
module dstd_fifo import dstd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  input  dstd_op_t push_op,
  output logic     push_ready,
  output logic     pop_valid,
  output dstd_op_t pop_op,
  input  logic     pop_ready
);

  dstd_op_t            entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                push_fire;
  logic                pop_fire;

  assign push_ready = count != (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_op     = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push_fire && !pop_fire) begin
        count <= count + (QUEUE_AW + 1)'(1);
      end else if (pop_fire && !push_fire) begin
        count <= count - (QUEUE_AW + 1)'(1);
      end
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
                   count <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
    else $error("queue fill count above its depth");
`endif

endmodule

FILE: sv/dstd_back.sv
module dstd_back import dstd_pkg::*; #(
  parameter int unsigned MAX_TILES = MAX_TILES_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [DATA_START_W-1:0] data_start,
  input  logic                    pop_valid,
  input  dstd_op_t                pop_op,
  output logic                    pop_ready,
  dstd_result_if.source           results
);

  localparam int unsigned AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

  logic [VALUE_W-1:0]  size_mem [MAX_TILES];
  logic [AW-1:0]       mem_addr;
  logic                pop_fire;

  logic                s1_valid;
  dstd_op_t            s1_op;
  logic [VALUE_W-1:0]  s1_rd;
  logic                s1_adv;

  logic [OFFSET_W-1:0] offset_acc;
  logic [VALUE_W-1:0]  uncomp_value;

  logic                    o_valid;
  logic [KIND_W-1:0]       o_kind;
  logic [TILE_INDEX_W-1:0] o_tile_index;
  logic [VALUE_W-1:0]      o_value;
  logic [OFFSET_W-1:0]     o_data_offset;
  logic [ERR_W-1:0]        o_error_code;
  logic                    o_last;

  assign s1_adv    = s1_valid && (!o_valid || results.ready);
  assign pop_ready = !s1_valid || s1_adv;
  assign pop_fire  = pop_valid && pop_ready;
  assign mem_addr  = pop_op.mem_index[AW-1:0];

  // Compressed sizes are stored in tile order and read back in the same order.
  always_ff @(posedge clk) begin
    if (pop_fire) begin
      if (pop_op.write_size) begin
        size_mem[mem_addr] <= pop_op.value;
      end
      s1_rd <= size_mem[mem_addr];
      s1_op <= pop_op;
    end
  end

  assign uncomp_value = s1_rd + s1_op.value;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_kind        <= s1_op.kind;
      o_tile_index  <= s1_op.tile_index[TILE_INDEX_W-1:0];
      o_error_code  <= s1_op.error_code;
      o_last        <= s1_op.last;
      o_value       <= s1_op.value;
      o_data_offset <= '0;
      if (s1_op.kind == KIND_ERROR) begin
        o_value <= '0;
      end else if (s1_op.kind == KIND_UNCOMP) begin
        o_value       <= uncomp_value;
        o_data_offset <= offset_acc;
        offset_acc    <= offset_acc + OFFSET_W'(s1_rd);
      end else if (s1_op.offset_start) begin
        // The last compressed size of a table loads the configured base.
        offset_acc <= OFFSET_W'(data_start);
      end else begin
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (pop_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        o_valid <= 1'b1;
      end else if (results.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  assign results.valid       = o_valid;
  assign results.kind        = o_kind;
  assign results.tile_index  = o_tile_index;
  assign results.value       = o_value;
  assign results.data_offset = o_data_offset;
  assign results.error_code  = o_error_code;
  assign results.last        = o_last;

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
                   s1_valid && !s1_adv |=> s1_valid && $stable(s1_op))
    else $error("read stage lost or changed a held entry");
  assert property (@(posedge clk) disable iff (rst)
                   results.valid && results.kind == KIND_ERROR
                   |-> results.last && results.error_code != ERR_NONE)
    else $error("error beat without last or without a code");
  assert property (@(posedge clk) disable iff (rst)
                   results.valid && results.kind != KIND_UNCOMP
                   |-> results.data_offset == '0)
    else $error("data offset set on a beat that carries none");
`endif

endmodule

FILE: sv/delta_size_table_decoder.sv
// Tile table decoder.
// The words channel carries one 16-bit table word per beat, with stream_end
// marking the last word of a stream. The results channel carries at most one
// beat per word: a key, a compressed size, an uncompressed size with its data
// offset, or an error, with last set on the final entry and on any error.
// tile_count and data_start must be written through the cfg port only while
// idle; the block itself does not enforce this. Throughput is one word per
// cycle while the queue has room. A front stage classifies each word and
// keeps all running sums, so the next word can follow in the next cycle; a
// four-entry queue lets the front and back stall independently. The back
// reads the stored compressed size from a one-port-per-cycle memory. Reset
// (synchronous, rst high) clears the control state and restarts the decoder
// at the key phase; the size memory is not cleared and is filled during the
// compressed-size phase before it is used. When the receiver stalls, the
// output register holds its beat, the queue fills, and words.ready drops
// once the queue is full.
module delta_size_table_decoder import dstd_pkg::*; #(
  parameter int unsigned MAX_TILES = MAX_TILES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  dstd_word_if.sink              words,
  dstd_result_if.source          results,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [CNT_CFG_W-1:0]    tile_count;
  logic [DATA_START_W-1:0] data_start;

  logic     push_valid;
  dstd_op_t push_op;
  logic     push_ready;
  logic     pop_valid;
  dstd_op_t pop_op;
  logic     pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_count <= '0;
      data_start <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TILE_COUNT: tile_count <= cfg_data[CNT_CFG_W-1:0];
        CFG_DATA_START: data_start <= cfg_data[DATA_START_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dstd_front #(
    .MAX_TILES(MAX_TILES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .tile_count(tile_count),
    .words     (words),
    .push_valid(push_valid),
    .push_op   (push_op),
    .push_ready(push_ready)
  );

  dstd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_op   (push_op),
    .push_ready(push_ready),
    .pop_valid (pop_valid),
    .pop_op    (pop_op),
    .pop_ready (pop_ready)
  );

  dstd_back #(
    .MAX_TILES(MAX_TILES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .data_start(data_start),
    .pop_valid (pop_valid),
    .pop_op    (pop_op),
    .pop_ready (pop_ready),
    .results   (results)
  );

endmodule
